// ===== hw/rtl/rbs_pkg.sv =====
// rbs_pkg: shared types, constants and arithmetic helpers for the ray/box slab block.
// No dependencies; every other file in hw/rtl imports it.
package rbs_pkg;

  localparam int WORD_W            = 32;
  localparam int FRAC_W            = 16;
  localparam int EPS_W             = 16;
  localparam int DIST_W            = 31;
  localparam int FACE_W            = 3;
  localparam int AXES              = 3;
  localparam int SLABS             = 2 * AXES;
  localparam int DIV_QW            = 32;
  localparam int DIV_STEPS_PER_STG = 2;
  localparam int DIV_STAGES        = DIV_QW / DIV_STEPS_PER_STG;
  localparam int SEL_STAGES        = 2;
  localparam int PNT_STAGES        = 2;
  localparam int NSTAGE            = 1 + DIV_STAGES + SEL_STAGES + PNT_STAGES;

  localparam logic signed [WORD_W-1:0] T_HI = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] T_LO = 32'sh8000_0000;
  localparam logic [WORD_W-1:0]        Q_NEG_LIMIT = 32'h8000_0000;
  localparam logic [FACE_W-1:0]        FACE_UPPER_OFS = 3'd3;

  localparam logic signed [WORD_W-1:0] RST_BOX_MIN = 32'sd0;
  localparam logic signed [WORD_W-1:0] RST_BOX_MAX = 32'sd65536;
  localparam logic [EPS_W-1:0]         RST_MIN_DIST = 16'd7;

  typedef enum logic [2:0] {
    REG_BOX_MIN_X    = 3'd0,
    REG_BOX_MIN_Y    = 3'd1,
    REG_BOX_MIN_Z    = 3'd2,
    REG_BOX_MAX_X    = 3'd3,
    REG_BOX_MAX_Y    = 3'd4,
    REG_BOX_MAX_Z    = 3'd5,
    REG_MIN_DISTANCE = 3'd6
  } cfg_reg_t;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t [AXES-1:0]         vec3_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] origin_x;
    logic signed [WORD_W-1:0] origin_y;
    logic signed [WORD_W-1:0] origin_z;
    logic signed [WORD_W-1:0] direction_x;
    logic signed [WORD_W-1:0] direction_y;
    logic signed [WORD_W-1:0] direction_z;
  } ray_in_t;

  typedef struct packed {
    logic                     is_hit;
    logic [DIST_W-1:0]        hit_distance;
    logic [FACE_W-1:0]        face_index;
    logic signed [WORD_W-1:0] hit_point_x;
    logic signed [WORD_W-1:0] hit_point_y;
    logic signed [WORD_W-1:0] hit_point_z;
  } hit_out_t;

  // per-slab side info that rides alongside the divider
  typedef struct packed {
    logic q_neg;     // quotient sign
    logic div_zero;  // direction component is zero
    logic diff_pos;
    logic diff_neg;
  } slab_flag_t;

  typedef struct packed {
    vec3_t                   o;
    vec3_t                   d;
    slab_flag_t [SLABS-1:0]  fl;
  } slab_ctx_t;

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [DIV_QW:0] div_step(input logic [DIV_QW-1:0] r,
                                                input logic [DIV_QW-1:0] dv,
                                                input logic              b);
    logic [DIV_QW:0] t;
    logic [DIV_QW:0] dx;
    t  = {r, b};
    dx = {1'b0, dv};
    if (t >= dx) begin
      return {1'b1, DIV_QW'(t - dx)};
    end else begin
      return {1'b0, t[DIV_QW-1:0]};
    end
  endfunction

  // quotient magnitude plus side info -> saturated signed Q16.16 distance
  function automatic word_t slab_sat(input logic [DIV_QW-1:0] q,
                                     input logic              ovf,
                                     input slab_flag_t        f);
    word_t res;
    if (f.div_zero) begin
      res = f.diff_pos ? T_HI : (f.diff_neg ? T_LO : '0);
    end else if (f.q_neg) begin
      res = (ovf || (q > Q_NEG_LIMIT)) ? T_LO : word_t'(-q);
    end else begin
      res = (ovf || q[DIV_QW-1]) ? T_HI : word_t'(q);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/rbs_div.sv =====
// rbs_div: pipelined restoring divider, (m << 16) / dv, two quotient bits per stage.
// Depends on rbs_pkg. Overflow flags quotients of 2^32 and up.
module rbs_div (
  input  logic                        clk,
  input  logic [rbs_pkg::DIV_STAGES-1:0] en,
  input  logic [rbs_pkg::DIV_QW:0]    m,
  input  logic [rbs_pkg::DIV_QW-1:0]  dv,
  output logic [rbs_pkg::DIV_QW-1:0]  q,
  output logic                        ovf
);
  import rbs_pkg::*;

  logic [DIV_QW-1:0] rem    [DIV_STAGES];
  logic [DIV_QW-1:0] quo    [DIV_STAGES];
  logic [DIV_QW-1:0] dvs    [DIV_STAGES];
  logic [FRAC_W-1:0] mlo    [DIV_STAGES];
  logic              ovf_r  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stg
    logic [DIV_QW-1:0] r_in, q_in, dv_in, r_nx, q_nx;
    logic [FRAC_W-1:0] mlo_in, mlo_nx;
    logic              ovf_in;

    if (k == 0) begin : g_first
      always_comb begin
        r_in   = DIV_QW'(m[DIV_QW:FRAC_W]);
        q_in   = '0;
        dv_in  = dv;
        mlo_in = m[FRAC_W-1:0];
        ovf_in = ({(FRAC_W-1)'(0), m} >= {dv, FRAC_W'(0)});
      end
    end else begin : g_next
      always_comb begin
        r_in   = rem[k-1];
        q_in   = quo[k-1];
        dv_in  = dvs[k-1];
        mlo_in = mlo[k-1];
        ovf_in = ovf_r[k-1];
      end
    end

    always_comb begin
      logic [DIV_QW:0] st;
      r_nx   = r_in;
      q_nx   = q_in;
      mlo_nx = mlo_in;
      for (int j = 0; j < DIV_STEPS_PER_STG; j++) begin
        st     = div_step(r_nx, dv_in, mlo_nx[FRAC_W-1]);
        mlo_nx = {mlo_nx[FRAC_W-2:0], 1'b0};
        r_nx   = st[DIV_QW-1:0];
        q_nx   = {q_nx[DIV_QW-2:0], st[DIV_QW]};
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k]   <= r_nx;
        quo[k]   <= q_nx;
        dvs[k]   <= dv_in;
        mlo[k]   <= mlo_nx;
        ovf_r[k] <= ovf_in;
      end
    end
  end

  assign q   = quo[DIV_STAGES-1];
  assign ovf = ovf_r[DIV_STAGES-1];

endmodule

// ===== hw/rtl/rbs_select.sv =====
// rbs_select: saturates slab distances, picks entry/exit with faces, then hit test.
// Depends on rbs_pkg. Two register stages.
module rbs_select (
  input  logic                                   clk,
  input  logic [rbs_pkg::SEL_STAGES-1:0]          en,
  input  logic [rbs_pkg::SLABS-1:0][rbs_pkg::DIV_QW-1:0] q,
  input  logic [rbs_pkg::SLABS-1:0]              ovf,
  input  rbs_pkg::slab_flag_t [rbs_pkg::SLABS-1:0] fl,
  input  logic [rbs_pkg::AXES-1:0]               dneg,
  input  logic [rbs_pkg::EPS_W-1:0]              eps,
  output logic                                   hit,
  output rbs_pkg::word_t                         t,
  output logic [rbs_pkg::FACE_W-1:0]             f
);
  import rbs_pkg::*;

  word_t             tn [AXES];
  word_t             tx [AXES];
  logic [FACE_W-1:0] fn [AXES];
  logic [FACE_W-1:0] fx [AXES];
  word_t             t0_nx, t1_nx, t0, t1, eps_w;
  logic [FACE_W-1:0] f0_nx, f1_nx, f0, f1;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      tn[i] = slab_sat(q[i], ovf[i], fl[i]);
      tx[i] = slab_sat(q[i+AXES], ovf[i+AXES], fl[i+AXES]);
      fn[i] = dneg[i] ? FACE_W'(i) + FACE_UPPER_OFS : FACE_W'(i);
      fx[i] = dneg[i] ? FACE_W'(i) : FACE_W'(i) + FACE_UPPER_OFS;
    end
    // entry: x unless y ties or wins; z only when strictly larger
    if (tn[0] > tn[1]) begin
      t0_nx = tn[0]; f0_nx = fn[0];
    end else begin
      t0_nx = tn[1]; f0_nx = fn[1];
    end
    if (tn[2] > t0_nx) begin
      t0_nx = tn[2]; f0_nx = fn[2];
    end
    if (tx[0] < tx[1]) begin
      t1_nx = tx[0]; f1_nx = fx[0];
    end else begin
      t1_nx = tx[1]; f1_nx = fx[1];
    end
    if (tx[2] < t1_nx) begin
      t1_nx = tx[2]; f1_nx = fx[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t0 <= t0_nx;
      t1 <= t1_nx;
      f0 <= f0_nx;
      f1 <= f1_nx;
    end
  end

  assign eps_w = word_t'({(WORD_W-EPS_W)'(0), eps});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      hit <= (t0 < t1) && (t1 > eps_w);
      t   <= (t0 > eps_w) ? t0 : t1;
      f   <= (t0 > eps_w) ? f0 : f1;
    end
  end

endmodule

// ===== hw/rtl/rbs_point.sv =====
// rbs_point: hit point = origin + floor(direction * t), saturated; zeroes misses.
// Depends on rbs_pkg. Multiply stage, then add/saturate into the output register.
module rbs_point (
  input  logic                           clk,
  input  logic [rbs_pkg::PNT_STAGES-1:0] en,
  input  rbs_pkg::vec3_t                 o,
  input  rbs_pkg::vec3_t                 d,
  input  logic                           hit,
  input  rbs_pkg::word_t                 t,
  input  logic [rbs_pkg::FACE_W-1:0]     f,
  output rbs_pkg::hit_out_t              res
);
  import rbs_pkg::*;

  localparam int PROD_W = 2 * WORD_W;
  localparam int SUM_W  = PROD_W - FRAC_W + 1;

  logic signed [PROD_W-1:0] prod [AXES];
  vec3_t                    o_r;
  logic                     hit_r;
  word_t                    t_r;
  logic [FACE_W-1:0]        f_r;
  word_t                    pt [AXES];
  hit_out_t                 res_nx;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < AXES; i++) begin
        prod[i] <= d[i] * t;
      end
      o_r   <= o;
      hit_r <= hit;
      t_r   <= t;
      f_r   <= f;
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] sum;
    for (int i = 0; i < AXES; i++) begin
      // arithmetic shift floors, matching round toward minus infinity
      sum = SUM_W'(o_r[i]) + SUM_W'($signed(prod[i][PROD_W-1:FRAC_W]));
      if (sum > SUM_W'(T_HI)) begin
        pt[i] = T_HI;
      end else if (sum < SUM_W'(T_LO)) begin
        pt[i] = T_LO;
      end else begin
        pt[i] = sum[WORD_W-1:0];
      end
    end
    res_nx = '0;
    if (hit_r) begin
      res_nx.is_hit       = 1'b1;
      res_nx.hit_distance = t_r[DIST_W-1:0];
      res_nx.face_index   = f_r;
      res_nx.hit_point_x  = pt[0];
      res_nx.hit_point_y  = pt[1];
      res_nx.hit_point_z  = pt[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      res <= res_nx;
    end
  end

endmodule

// ===== hw/rtl/ray_box_slab_intersect.sv =====
// Ray vs. axis-aligned box (slab method), Q16.16, fully pipelined: one ray per cycle
// while out_ready is high. Depth is set by the slab divider, six restoring dividers
// resolving two quotient bits per stage over 16 stages; around it sit one prep stage,
// two select stages and two hit-point stages. Every stage has its own valid bit and a
// stage only holds when it is full and the one after it holds, so bubbles are squeezed
// out and an input beat can be taken while a result beat waits, if any stage is empty.
// Config writes are always accepted; write only while the pipe is empty.
// Depends on rbs_pkg, rbs_div, rbs_select, rbs_point.
module ray_box_slab_intersect (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rbs_pkg::ray_in_t       in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rbs_pkg::hit_out_t      out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [rbs_pkg::WORD_W-1:0] cfg_data
);
  import rbs_pkg::*;

  localparam int SEL_FIRST = 1 + DIV_STAGES;
  localparam int PNT_FIRST = SEL_FIRST + SEL_STAGES;
  localparam int LAST      = NSTAGE - 1;

  // config registers
  vec3_t             box_min, box_max;
  logic [EPS_W-1:0]  min_distance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min      <= {AXES{RST_BOX_MIN}};
      box_max      <= {AXES{RST_BOX_MAX}};
      min_distance <= RST_MIN_DIST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BOX_MIN_X:    box_min[0]   <= cfg_data;
        REG_BOX_MIN_Y:    box_min[1]   <= cfg_data;
        REG_BOX_MIN_Z:    box_min[2]   <= cfg_data;
        REG_BOX_MAX_X:    box_max[0]   <= cfg_data;
        REG_BOX_MAX_Y:    box_max[1]   <= cfg_data;
        REG_BOX_MAX_Z:    box_max[2]   <= cfg_data;
        REG_MIN_DISTANCE: min_distance <= cfg_data[EPS_W-1:0];
        default:          ;  // unmapped index, dropped
      endcase
    end
  end

  // pipeline control: valid per stage, ready ripples back from the output
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE:0]   rdy;
  logic [NSTAGE-1:0] en;

  always_comb begin
    rdy[NSTAGE] = out_ready;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign en        = rdy[NSTAGE-1:0];
  assign in_ready  = rdy[0];
  assign out_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // prep: plane - origin per slab, operand magnitudes and sign info.
  // Negative direction swaps which plane is entry and which is exit.
  vec3_t                           o_in, d_in;
  logic [SLABS-1:0][DIV_QW:0]      m_nx;
  logic [AXES-1:0][DIV_QW-1:0]     dv_nx;
  slab_flag_t [SLABS-1:0]          fl_nx;

  assign o_in = {in_data.origin_z, in_data.origin_y, in_data.origin_x};
  assign d_in = {in_data.direction_z, in_data.direction_y, in_data.direction_x};

  always_comb begin
    logic signed [WORD_W:0] diff;
    word_t                  plane;
    for (int s = 0; s < SLABS; s++) begin
      if (s < AXES) begin
        plane = d_in[s % AXES][WORD_W-1] ? box_max[s % AXES] : box_min[s % AXES];
      end else begin
        plane = d_in[s % AXES][WORD_W-1] ? box_min[s % AXES] : box_max[s % AXES];
      end
      diff  = (WORD_W+1)'(plane) - (WORD_W+1)'(o_in[s % AXES]);
      m_nx[s]           = diff[WORD_W] ? (WORD_W+1)'(-diff) : diff;
      fl_nx[s].q_neg    = diff[WORD_W] ^ d_in[s % AXES][WORD_W-1];
      fl_nx[s].div_zero = (d_in[s % AXES] == '0);
      fl_nx[s].diff_pos = !diff[WORD_W] && (diff != '0);
      fl_nx[s].diff_neg = diff[WORD_W];
    end
    for (int i = 0; i < AXES; i++) begin
      dv_nx[i] = d_in[i][WORD_W-1] ? DIV_QW'(-d_in[i]) : DIV_QW'(d_in[i]);
    end
  end

  logic [SLABS-1:0][DIV_QW:0]  m_q;
  logic [AXES-1:0][DIV_QW-1:0] dv_q;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m_q  <= m_nx;
      dv_q <= dv_nx;
    end
  end

  // side line: ray and slab flags ride along to the hit-point stage
  slab_ctx_t ctx [PNT_FIRST];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ctx[0].o  <= o_in;
      ctx[0].d  <= d_in;
      ctx[0].fl <= fl_nx;
    end
    for (int k = 1; k < PNT_FIRST; k++) begin
      if (en[k]) begin
        ctx[k] <= ctx[k-1];
      end
    end
  end

  // slab dividers
  logic [SLABS-1:0][DIV_QW-1:0] q_div;
  logic [SLABS-1:0]             ovf_div;

  for (genvar s = 0; s < SLABS; s++) begin : g_div
    rbs_div u_div (
      .clk (clk),
      .en  (en[SEL_FIRST-1:1]),
      .m   (m_q[s]),
      .dv  (dv_q[s % AXES]),
      .q   (q_div[s]),
      .ovf (ovf_div[s])
    );
  end

  // entry/exit pick and hit test
  logic              sel_hit;
  word_t             sel_t;
  logic [FACE_W-1:0] sel_f;
  logic [AXES-1:0]   dneg;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      dneg[i] = ctx[SEL_FIRST-1].d[i][WORD_W-1];
    end
  end

  rbs_select u_sel (
    .clk  (clk),
    .en   (en[PNT_FIRST-1:SEL_FIRST]),
    .q    (q_div),
    .ovf  (ovf_div),
    .fl   (ctx[SEL_FIRST-1].fl),
    .dneg (dneg),
    .eps  (min_distance),
    .hit  (sel_hit),
    .t    (sel_t),
    .f    (sel_f)
  );

  // hit point and output register
  rbs_point u_pnt (
    .clk (clk),
    .en  (en[LAST:PNT_FIRST]),
    .o   (ctx[PNT_FIRST-1].o),
    .d   (ctx[PNT_FIRST-1].d),
    .hit (sel_hit),
    .t   (sel_t),
    .f   (sel_f),
    .res (out_data)
  );

endmodule

// ===== hw/rtl/rbs_checker.sv =====
// rbs_checker: port-level assertions for ray_box_slab_intersect, bound to the top.
// Depends on rbs_pkg.
module rbs_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input rbs_pkg::hit_out_t out_data
);
  import rbs_pkg::*;

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_hit |->
      out_data.hit_distance == '0 && out_data.face_index == '0 &&
      out_data.hit_point_x == '0 && out_data.hit_point_y == '0 &&
      out_data.hit_point_z == '0)
    else $error("miss beat carries nonzero fields");

  a_face_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_hit |-> out_data.face_index <= 3'd5)
    else $error("face index out of range");

  // a free output stage can always take a new ray
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked");

endmodule

bind ray_box_slab_intersect rbs_checker u_rbs_checker (.*);

// ===== dv/tb_ray_box_slab_intersect.sv =====
// Self-checking testbench for ray_box_slab_intersect: directed rays from a table, then
// random rays under several box settings, each result checked against its table entry or an in-bench model.
// Depends on rbs_pkg and the ray_box_slab_intersect RTL.
module tb_ray_box_slab_intersect;
  import rbs_pkg::*;

  localparam int LATENCY    = 21;
  localparam int WDOG_LIMIT = 20000;
  localparam int N_RANDOM   = 480;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  ray_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  hit_out_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [2:0] cfg_index;
  logic [WORD_W-1:0] cfg_data;

  ray_box_slab_intersect i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the box registers, kept in step with every config write.
  logic signed [63:0] box_lo [3];
  logic signed [63:0] box_hi [3];
  logic signed [63:0] eps_dist;

  hit_out_t pending_hits [$];
  int       n_errors;
  int       idle_cycles;
  bit       rx_stall_mode;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  // (plane - origin) / direction in Q16.16, truncated toward zero, saturated.
  // A zero direction acts as +inf reciprocal.
  function automatic logic signed [63:0] slab_t(input logic signed [63:0] diff,
                                                input logic signed [63:0] dir);
    logic [63:0] q;
    logic [63:0] md;
    logic [63:0] mv;
    bit          neg;
    if (dir == 0) return diff > 0 ? 64'sh7FFF_FFFF : (diff < 0 ? -64'sh8000_0000 : 64'sd0);
    neg = (diff < 0) != (dir < 0);
    mv  = diff < 0 ? -diff : diff;
    md  = dir < 0 ? -dir : dir;
    q   = (mv << 16) / md;
    if (neg) return q > 64'h8000_0000 ? -64'sh8000_0000 : -$signed(q);
    return q > 64'h7FFF_FFFF ? 64'sh7FFF_FFFF : $signed(q);
  endfunction

  // origin + dir * t, product floored to Q16.16
  function automatic logic signed [31:0] hit_coord(input logic signed [63:0] o,
                                                   input logic signed [63:0] d,
                                                   input logic signed [63:0] t);
    logic signed [63:0] p;
    p = (d * t) >>> 16;
    return 32'(sat32(o + p));
  endfunction

  function automatic hit_out_t trace_ray(input ray_in_t r);
    logic signed [63:0] o [3];
    logic signed [63:0] d [3];
    logic signed [63:0] tn [3];
    logic signed [63:0] tx [3];
    logic signed [63:0] t0, t1, t;
    logic [2:0] f0, f1, f;
    hit_out_t h;
    o[0] = r.origin_x;    o[1] = r.origin_y;    o[2] = r.origin_z;
    d[0] = r.direction_x; d[1] = r.direction_y; d[2] = r.direction_z;
    for (int a = 0; a < 3; a++) begin
      if (d[a] >= 0) begin
        tn[a] = slab_t(box_lo[a] - o[a], d[a]);
        tx[a] = slab_t(box_hi[a] - o[a], d[a]);
      end else begin
        tn[a] = slab_t(box_hi[a] - o[a], d[a]);
        tx[a] = slab_t(box_lo[a] - o[a], d[a]);
      end
    end
    // entry: x wins only on strict; z only on strict
    if (tn[0] > tn[1]) begin t0 = tn[0]; f0 = d[0] >= 0 ? 3'd0 : 3'd3; end
    else begin t0 = tn[1]; f0 = d[1] >= 0 ? 3'd1 : 3'd4; end
    if (tn[2] > t0) begin t0 = tn[2]; f0 = d[2] >= 0 ? 3'd2 : 3'd5; end
    if (tx[0] < tx[1]) begin t1 = tx[0]; f1 = d[0] >= 0 ? 3'd3 : 3'd0; end
    else begin t1 = tx[1]; f1 = d[1] >= 0 ? 3'd4 : 3'd1; end
    if (tx[2] < t1) begin t1 = tx[2]; f1 = d[2] >= 0 ? 3'd5 : 3'd2; end
    h = '0;
    if (!(t0 < t1 && t1 > eps_dist)) return h;
    if (t0 > eps_dist) begin t = t0; f = f0; end
    else begin t = t1; f = f1; end
    h.is_hit       = 1'b1;
    h.hit_distance = t[30:0];
    h.face_index   = f;
    h.hit_point_x  = hit_coord(o[0], d[0], t);
    h.hit_point_y  = hit_coord(o[1], d[1], t);
    h.hit_point_z  = hit_coord(o[2], d[2], t);
    return h;
  endfunction

  // One write beat; valid stays up for back-to-back writes, the caller drops it.
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_MIN_DISTANCE) eps_dist = {48'd0, val[15:0]};
    else if (idx < REG_BOX_MAX_X) box_lo[idx] = $signed(val);
    else box_hi[idx - REG_BOX_MAX_X] = $signed(val);
    @(negedge clk);
  endtask

  task automatic set_box(input logic [31:0] lx, ly, lz, hx, hy, hz, eps);
    write_reg(REG_BOX_MIN_X, lx);
    write_reg(REG_BOX_MIN_Y, ly);
    write_reg(REG_BOX_MIN_Z, lz);
    write_reg(REG_BOX_MAX_X, hx);
    write_reg(REG_BOX_MAX_Y, hy);
    write_reg(REG_BOX_MAX_Z, hz);
    write_reg(REG_MIN_DISTANCE, eps);
    cfg_valid <= 1'b0;
  endtask

  // Wait for the pipe to empty before touching registers.
  task automatic drain();
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // One beat; valid is held across back-to-back beats, the caller drops it.
  task automatic send_ray(input ray_in_t r, input bit has_ref, input hit_out_t ref_hit);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    pending_hits.push_back(has_ref ? ref_hit : trace_ray(r));
    @(negedge clk);
  endtask

  task automatic gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  // Coordinate mixing box-scale values with full-range noise.
  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2:       return 32'($signed($urandom_range(0, 1 << 16)));
      3:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 64 << 16)) - (32 << 16));
    endcase
  endfunction

  function automatic logic [31:0] rnd_dir();
    case ($urandom_range(0, 6))
      0:       return 32'd0;
      1:       return $urandom;
      2:       return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
      3:       return 32'($signed($urandom_range(0, 64)) - 32);
      default: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
    endcase
  endfunction

  typedef struct {
    ray_in_t  r;
    bit       has_ref;
    hit_out_t h;
  } ray_case_t;

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MAXW = 32'h7FFF_FFFF;
  localparam logic [31:0] MINW = 32'h8000_0000;

  // Directed rays against the reset box [0,1]^3 with epsilon 7.
  ray_case_t ray_table [] = '{
    // straight down +x from outside: enters lower x face at t=1
    '{'{-ONE, ONE/2, ONE/2, ONE, 0, 0}, 1'b1,
      '{1'b1, 31'h1_0000, 3'd0, 0, ONE/2, ONE/2}},
    // from inside along +x: exit upper x at t=0.5
    '{'{ONE/2, ONE/2, ONE/2, ONE, 0, 0}, 1'b1,
      '{1'b1, 31'h8000, 3'd3, ONE, ONE/2, ONE/2}},
    // pointing away: miss, all zero
    '{'{-ONE, ONE/2, ONE/2, -ONE, 0, 0}, 1'b1, '0},
    // zero direction entirely, origin inside: exit distance saturates
    '{'{ONE/2, ONE/2, ONE/2, 0, 0, 0}, 1'b0, '0},
    '{'{0, 0, 0, 0, 0, 0}, 1'b0, '0},
    // single-axis directions: negative on each axis, then positive y and z
    '{'{2*ONE, ONE/2, ONE/2, -ONE, 0, 0}, 1'b0, '0},
    '{'{ONE/2, 2*ONE, ONE/2, 0, -ONE, 0}, 1'b0, '0},
    '{'{ONE/2, ONE/2, 2*ONE, 0, 0, -ONE}, 1'b0, '0},
    '{'{ONE/2, -ONE, ONE/2, 0, ONE, 0}, 1'b0, '0},
    '{'{ONE/2, ONE/2, -ONE, 0, 0, ONE}, 1'b0, '0},
    // diagonal ties between axes
    '{'{-ONE, -ONE, -ONE, ONE, ONE, ONE}, 1'b0, '0},
    '{'{2*ONE, 2*ONE, 2*ONE, -ONE, -ONE, -ONE}, 1'b0, '0},
    '{'{-ONE, -ONE, ONE/2, ONE, ONE, 0}, 1'b0, '0},
    // field extremes
    '{'{MAXW, MAXW, MAXW, MAXW, MAXW, MAXW}, 1'b0, '0},
    '{'{MINW, MINW, MINW, MAXW, MAXW, MAXW}, 1'b0, '0},
    '{'{MINW, MINW, MINW, MINW, MINW, MINW}, 1'b0, '0},
    '{'{MAXW, MAXW, MAXW, MINW, MINW, MINW}, 1'b0, '0},
    '{'{MINW, ONE/2, ONE/2, 1, 0, 0}, 1'b0, '0},
    '{'{MAXW, ONE/2, ONE/2, -1, 0, 0}, 1'b0, '0},
    // tiny direction: slab distances saturate
    '{'{-ONE, ONE/2, ONE/2, 1, 1, 1}, 1'b0, '0},
    // grazing near epsilon
    '{'{-1, ONE/2, ONE/2, ONE, 0, 0}, 1'b0, '0},
    '{'{ONE - 3, ONE/2, ONE/2, ONE, 0, 0}, 1'b0, '0},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0}
  };

  // Receiver: stalls in alternating modes, checks every result beat.
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if ($urandom_range(0, 99) < 2) rx_stall_mode <= ~rx_stall_mode;
    else out_ready <= rx_stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  always @(posedge clk) begin
    hit_out_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_hits.size() == 0) begin
        $error("result beat with no ray outstanding");
        n_errors++;
      end else begin
        e = pending_hits.pop_front();
        if (out_data.is_hit !== e.is_hit) begin
          $error("is_hit exp %0d got %0d", e.is_hit, out_data.is_hit); n_errors++;
        end
        if (out_data.hit_distance !== e.hit_distance) begin
          $error("hit_distance exp %h got %h", e.hit_distance, out_data.hit_distance);
          n_errors++;
        end
        if (out_data.face_index !== e.face_index) begin
          $error("face_index exp %0d got %0d", e.face_index, out_data.face_index);
          n_errors++;
        end
        if (out_data.hit_point_x !== e.hit_point_x) begin
          $error("hit_point_x exp %h got %h", e.hit_point_x, out_data.hit_point_x);
          n_errors++;
        end
        if (out_data.hit_point_y !== e.hit_point_y) begin
          $error("hit_point_y exp %h got %h", e.hit_point_y, out_data.hit_point_y);
          n_errors++;
        end
        if (out_data.hit_point_z !== e.hit_point_z) begin
          $error("hit_point_z exp %h got %h", e.hit_point_z, out_data.hit_point_z);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: any beat on the input, output or config side resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= WDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int burst;
    ray_in_t r;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_BOX_MIN_X;
    cfg_data = '0;
    out_ready = 1'b0;
    rx_stall_mode = 1'b0;
    n_errors = 0;
    idle_cycles = 0;
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = 0;
      box_hi[a] = 64'sd65536;
    end
    eps_dist = 7;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, reset box
    foreach (ray_table[k]) begin
      send_ray(ray_table[k].r, ray_table[k].has_ref, ray_table[k].h);
      if ($urandom_range(0, 3) == 0) gap();
    end
    in_valid <= 1'b0;

    // random phases, each under its own box; the second spans the full range, the last is flat
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 32'd0);
        1: set_box(MINW, MINW, MINW, MAXW, MAXW, MAXW, 32'hFFFF);
        2: set_box(2*ONE, 0, 0, -2*ONE, 3*ONE, ONE, 32'd100); // x inverted
        3: set_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        4: set_box(-ONE/4, -3*ONE, 0, 4*ONE, ONE/2, 5*ONE, $urandom_range(0, 65535));
        default: set_box(0, 0, 0, 0, 0, 0, 32'd0); // flat box
      endcase
      for (int n = 0; n < N_RANDOM / 6; n += burst) begin
        burst = $urandom_range(1, 16);
        for (int b = 0; b < burst; b++) begin
          r.origin_x = rnd_coord();
          r.origin_y = rnd_coord();
          r.origin_z = rnd_coord();
          r.direction_x = rnd_dir();
          r.direction_y = rnd_dir();
          r.direction_z = rnd_dir();
          send_ray(r, 1'b0, '0);
        end
        if ($urandom_range(0, 2) != 0) gap();
        // hold off once until the pipe is empty
        if (n == 0 && ph == 2) begin
          in_valid <= 1'b0;
          while (pending_hits.size() != 0) @(negedge clk);
        end
      end
      in_valid <= 1'b0;
    end

    while (pending_hits.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (n_errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
